/* rtl/uart16550_pkg.sv */
// Shared types, register map and bit constants of the 16550-style UART register model.
package uart16550_pkg;

  // Event kind carried in the input tuser.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2,
    FUNC_DRAIN = 2'd3
  } func_t;

  // Completion status of a request.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LOAD_FAULT  = 2'd1,
    ST_STORE_FAULT = 2'd2,
    ST_RSVD        = 2'd3
  } status_t;

  // Register offsets within the device region.
  localparam logic [7:0] REG_RBR = 8'd0;
  localparam logic [7:0] REG_IER = 8'd1;
  localparam logic [7:0] REG_IIR = 8'd2;
  localparam logic [7:0] REG_LCR = 8'd3;
  localparam logic [7:0] REG_MCR = 8'd4;
  localparam logic [7:0] REG_LSR = 8'd5;
  localparam logic [7:0] REG_MSR = 8'd6;
  localparam logic [7:0] REG_SCR = 8'd7;

  // The only legal bus access width in bytes.
  localparam logic [3:0] ACCESS_BYTE = 4'd1;

  // Register bit fields.
  localparam int unsigned IER_RX_BIT = 0;
  localparam int unsigned IER_TX_BIT = 1;
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] LSR_THRE  = 8'h20;
  localparam logic [7:0] LSR_TEMT  = 8'h40;
  localparam logic [7:0] IIR_NONE  = 8'h01;
  localparam logic [7:0] IIR_THRE  = 8'h02;
  localparam logic [7:0] IIR_RXD   = 8'h04;
  localparam logic [7:0] IIR_FIFOS = 8'hC0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // execute the request on the input channel
    logic out_load;    // load the output register
    logic out_drain;   // output register takes a drained transmit byte
    logic drain_next;  // advance the drain by one byte
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tx_empty;    // transmit queue holds no byte
    logic drain_last;  // the byte being drained is the final one
  } dp_sts_t;

endpackage

/* rtl/uart16550_ctrl.sv */
// Controller state machine: request acceptance, response sequencing and drain walk.
module uart16550_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  uart16550_pkg::func_t      in_func,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  uart16550_pkg::dp_sts_t    sts,
  output uart16550_pkg::ctrl_cmd_t  cmd
);
  import uart16550_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          if (in_func == FUNC_DRAIN && !sts.tx_empty) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_drain  = 1'b1;
          cmd.drain_next = 1'b1;
          if (sts.drain_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid follows loads and consumer takes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/uart16550_dp.sv */
// Datapath: UART registers, receive and transmit queues, response and output registers.
module uart16550_dp #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  uart16550_pkg::func_t      in_func,
  input  logic [7:0]                in_offset,
  input  logic [3:0]                in_access_size,
  input  logic [7:0]                in_write_data,
  input  logic [7:0]                in_rx_byte,
  input  uart16550_pkg::ctrl_cmd_t  cmd,
  output uart16550_pkg::dp_sts_t    sts,
  output logic [7:0]                out_read_data,
  output uart16550_pkg::status_t    out_status,
  output logic                      out_tx_valid,
  output logic [7:0]                out_tx_data,
  output logic                      out_last,
  output logic                      out_irq
);
  import uart16550_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Architectural registers.
  logic [7:0]       dll_r, dll_nxt;
  logic [7:0]       dlm_r, dlm_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       fcr_r, fcr_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [7:0]       mcr_r, mcr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic             thre_acked_r, thre_acked_nxt;

  // Queue pointers and counts.
  logic [PTR_W-1:0] rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [PTR_W-1:0] rx_wr_ptr_r, rx_wr_ptr_nxt;
  logic [CNT_W-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [PTR_W-1:0] tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [PTR_W-1:0] tx_wr_ptr_r, tx_wr_ptr_nxt;
  logic [CNT_W-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [CNT_W-1:0] drain_left_r, drain_left_nxt;

  // Queue storage and registered read data.
  logic [7:0]       rx_mem [FIFO_DEPTH];
  logic [7:0]       tx_mem [FIFO_DEPTH];
  logic [7:0]       rx_q_r;
  logic [7:0]       tx_q_r;
  logic             rx_we;
  logic             tx_we;
  logic             tx_re;
  logic [PTR_W-1:0] tx_rd_addr;

  // Response of the request in flight.
  logic [7:0]       rsp_rdata_r, rsp_rdata_nxt;
  status_t          rsp_status_r, rsp_status_nxt;
  logic             rsp_use_rxq_r, rsp_use_rxq_nxt;

  // Output register.
  logic [7:0]       out_read_data_r;
  status_t          out_status_r;
  logic             out_tx_valid_r;
  logic [7:0]       out_tx_data_r;
  logic             out_last_r;
  logic             out_irq_r;

  logic             dlab;
  logic             rx_pend;
  logic             thre_pend;
  logic             irq_now;
  logic [PTR_W-1:0] rx_rd_inc;
  logic [PTR_W-1:0] rx_wr_inc;
  logic [PTR_W-1:0] tx_rd_inc;
  logic [PTR_W-1:0] tx_wr_inc;

  assign dlab      = lcr_r[LCR_DLAB_BIT];
  assign rx_pend   = ier_r[IER_RX_BIT] && (rx_cnt_r != '0);
  assign thre_pend = ier_r[IER_TX_BIT] && (tx_cnt_r == '0) && !thre_acked_r;
  assign irq_now   = rx_pend || thre_pend;

  // Circular pointer increments.
  assign rx_rd_inc = (rx_rd_ptr_r == PTR_LAST) ? '0 : rx_rd_ptr_r + 1'b1;
  assign rx_wr_inc = (rx_wr_ptr_r == PTR_LAST) ? '0 : rx_wr_ptr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_ptr_r == PTR_LAST) ? '0 : tx_rd_ptr_r + 1'b1;
  assign tx_wr_inc = (tx_wr_ptr_r == PTR_LAST) ? '0 : tx_wr_ptr_r + 1'b1;

  assign sts.tx_empty   = (tx_cnt_r == '0);
  assign sts.drain_last = (drain_left_r == CNT_ONE);

  // Request execution and drain stepping.
  always_comb begin
    dll_nxt         = dll_r;
    dlm_nxt         = dlm_r;
    ier_nxt         = ier_r;
    fcr_nxt         = fcr_r;
    lcr_nxt         = lcr_r;
    mcr_nxt         = mcr_r;
    scr_nxt         = scr_r;
    thre_acked_nxt  = thre_acked_r;
    rx_rd_ptr_nxt   = rx_rd_ptr_r;
    rx_wr_ptr_nxt   = rx_wr_ptr_r;
    rx_cnt_nxt      = rx_cnt_r;
    tx_rd_ptr_nxt   = tx_rd_ptr_r;
    tx_wr_ptr_nxt   = tx_wr_ptr_r;
    tx_cnt_nxt      = tx_cnt_r;
    drain_left_nxt  = drain_left_r;
    rsp_rdata_nxt   = rsp_rdata_r;
    rsp_status_nxt  = rsp_status_r;
    rsp_use_rxq_nxt = rsp_use_rxq_r;
    rx_we           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    tx_rd_addr      = tx_rd_ptr_r;

    if (cmd.exec) begin
      rsp_rdata_nxt   = '0;
      rsp_status_nxt  = ST_OK;
      rsp_use_rxq_nxt = 1'b0;
      unique case (in_func)
        FUNC_READ: begin
          if (in_access_size != ACCESS_BYTE) begin
            rsp_status_nxt = ST_LOAD_FAULT;
          end else begin
            unique case (in_offset)
              REG_RBR: begin
                if (dlab) begin
                  rsp_rdata_nxt = dll_r;
                end else if (rx_cnt_r != '0) begin
                  rsp_use_rxq_nxt = 1'b1;
                  rx_rd_ptr_nxt   = rx_rd_inc;
                  rx_cnt_nxt      = rx_cnt_r - 1'b1;
                end
              end
              REG_IER: rsp_rdata_nxt = dlab ? dlm_r : {4'b0000, ier_r};
              REG_IIR: begin
                // Receive data outranks THR empty; reading acknowledges THR empty when it is reported.
                if (rx_pend) begin
                  rsp_rdata_nxt = IIR_FIFOS | IIR_RXD;
                end else if (thre_pend) begin
                  rsp_rdata_nxt  = IIR_FIFOS | IIR_THRE;
                  thre_acked_nxt = 1'b1;
                end else begin
                  rsp_rdata_nxt = IIR_FIFOS | IIR_NONE;
                end
              end
              REG_LCR: rsp_rdata_nxt = lcr_r;
              REG_MCR: rsp_rdata_nxt = mcr_r;
              REG_LSR: begin
                rsp_rdata_nxt = ((rx_cnt_r != '0) ? LSR_DR : 8'h00) |
                                ((tx_cnt_r != CNT_FULL) ? LSR_THRE : 8'h00) |
                                ((tx_cnt_r == '0) ? LSR_TEMT : 8'h00);
              end
              REG_SCR: rsp_rdata_nxt = scr_r;
              // MSR and offsets past the map read as zero.
              default: rsp_rdata_nxt = '0;
            endcase
          end
        end
        FUNC_WRITE: begin
          if (in_access_size != ACCESS_BYTE) begin
            rsp_status_nxt = ST_STORE_FAULT;
          end else begin
            unique case (in_offset)
              REG_RBR: begin
                if (dlab) begin
                  dll_nxt = in_write_data;
                end else begin
                  if (tx_cnt_r != CNT_FULL) begin
                    tx_we         = 1'b1;
                    tx_wr_ptr_nxt = tx_wr_inc;
                    tx_cnt_nxt    = tx_cnt_r + 1'b1;
                  end
                  thre_acked_nxt = 1'b0;
                end
              end
              REG_IER: begin
                if (dlab) begin
                  dlm_nxt = in_write_data;
                end else begin
                  ier_nxt        = in_write_data[3:0];
                  thre_acked_nxt = 1'b0;
                end
              end
              REG_IIR: fcr_nxt = in_write_data;
              REG_LCR: lcr_nxt = in_write_data;
              REG_MCR: mcr_nxt = in_write_data;
              REG_SCR: scr_nxt = in_write_data;
              // LSR, MSR and offsets past the map ignore writes.
              default: ;
            endcase
          end
        end
        FUNC_RX: begin
          // A byte arriving at a full queue is dropped.
          if (rx_cnt_r != CNT_FULL) begin
            rx_we         = 1'b1;
            rx_wr_ptr_nxt = rx_wr_inc;
            rx_cnt_nxt    = rx_cnt_r + 1'b1;
          end
        end
        FUNC_DRAIN: begin
          // Take the whole queue and prefetch its oldest byte.
          drain_left_nxt = tx_cnt_r;
          tx_cnt_nxt     = '0;
          thre_acked_nxt = 1'b0;
          tx_re          = 1'b1;
        end
        default: ;
      endcase
    end

    if (cmd.drain_next) begin
      tx_rd_ptr_nxt  = tx_rd_inc;
      drain_left_nxt = drain_left_r - 1'b1;
      tx_re          = 1'b1;
      tx_rd_addr     = tx_rd_inc;
    end
  end

  // Receive queue storage with registered read.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_ptr_r] <= in_rx_byte;
    end
    if (cmd.exec) begin
      rx_q_r <= rx_mem[rx_rd_ptr_r];
    end
  end

  // Transmit queue storage with registered read.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_ptr_r] <= in_write_data;
    end
    if (tx_re) begin
      tx_q_r <= tx_mem[tx_rd_addr];
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dll_r        <= '0;
      dlm_r        <= '0;
      ier_r        <= '0;
      fcr_r        <= '0;
      lcr_r        <= '0;
      mcr_r        <= '0;
      scr_r        <= '0;
      thre_acked_r <= 1'b0;
      rx_rd_ptr_r  <= '0;
      rx_wr_ptr_r  <= '0;
      rx_cnt_r     <= '0;
      tx_rd_ptr_r  <= '0;
      tx_wr_ptr_r  <= '0;
      tx_cnt_r     <= '0;
      drain_left_r <= '0;
    end else begin
      dll_r        <= dll_nxt;
      dlm_r        <= dlm_nxt;
      ier_r        <= ier_nxt;
      fcr_r        <= fcr_nxt;
      lcr_r        <= lcr_nxt;
      mcr_r        <= mcr_nxt;
      scr_r        <= scr_nxt;
      thre_acked_r <= thre_acked_nxt;
      rx_rd_ptr_r  <= rx_rd_ptr_nxt;
      rx_wr_ptr_r  <= rx_wr_ptr_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      tx_rd_ptr_r  <= tx_rd_ptr_nxt;
      tx_wr_ptr_r  <= tx_wr_ptr_nxt;
      tx_cnt_r     <= tx_cnt_nxt;
      drain_left_r <= drain_left_nxt;
    end
  end

  // Response and output payload registers.
  always_ff @(posedge clk) begin
    rsp_rdata_r   <= rsp_rdata_nxt;
    rsp_status_r  <= rsp_status_nxt;
    rsp_use_rxq_r <= rsp_use_rxq_nxt;
    if (cmd.out_load) begin
      out_irq_r <= irq_now;
      if (cmd.out_drain) begin
        out_read_data_r <= '0;
        out_status_r    <= ST_OK;
        out_tx_valid_r  <= 1'b1;
        out_tx_data_r   <= tx_q_r;
        out_last_r      <= sts.drain_last;
      end else begin
        out_read_data_r <= rsp_use_rxq_r ? rx_q_r : rsp_rdata_r;
        out_status_r    <= rsp_status_r;
        out_tx_valid_r  <= 1'b0;
        out_tx_data_r   <= '0;
        out_last_r      <= 1'b1;
      end
    end
  end

  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;
  assign out_tx_valid  = out_tx_valid_r;
  assign out_tx_data   = out_tx_data_r;
  assign out_last      = out_last_r;
  assign out_irq       = out_irq_r;

endmodule

/* rtl/uart_16550_register_model_unit.sv */
// Top level of the 16550-style UART register model: channel packing, controller and datapath.
//
// Usage:
//   The input channel carries one event per request: a bus read, a bus write, a byte
//   received from the line, or a drain of the transmit queue (event kind in in_tuser).
//   The output channel returns one response per bus access or received byte, and for
//   a drain one response per queued transmit byte (tx_valid set, tlast on the final
//   byte), or a single empty response when the queue holds nothing. Every response
//   carries the interrupt line level after the event.
//   Timing: a request is executed at the edge that accepts it; its response is registered
//   and moves to the output register when that is free. The block takes one request at a
//   time: a new one is accepted only after the previous response is loaded. A drain moves
//   one byte per cycle, while the receiver does not stall, out of the transmit queue
//   memory's registered read port. The output register decouples the channels: the next
//   request is accepted while a response still waits. When the receiver stalls, the
//   response holds and the block stops after the next response is ready. Reset (rst_n
//   low, synchronous) clears state, output valid, architectural registers, queue pointers
//   and counts, not payload registers; storage is not cleared and needs no clearing pass.
module uart_16550_register_model_unit #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // offset[7:0], access_size[11:8], write_data[19:12],
                                  // rx_byte[27:20], zero pad[31:28]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data[7:0], tx_data[15:8], irq[16], zero pad[23:17]
  output logic [2:0]  out_tuser,  // status[1:0], tx_valid[2]
  output logic        out_tlast   // last
);
  import uart16550_pkg::*;

  func_t      in_func;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;
  logic [7:0] read_data;
  status_t    status;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic       irq;

  assign in_func = func_t'(in_tuser);

  uart16550_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_func),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  uart16550_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_offset      (in_tdata[7:0]),
    .in_access_size (in_tdata[11:8]),
    .in_write_data  (in_tdata[19:12]),
    .in_rx_byte     (in_tdata[27:20]),
    .cmd            (cmd),
    .sts            (sts),
    .out_read_data  (read_data),
    .out_status     (status),
    .out_tx_valid   (tx_valid),
    .out_tx_data    (tx_data),
    .out_last       (out_tlast),
    .out_irq        (irq)
  );

  // Pack the response fields.
  assign out_tdata = {7'b0000000, irq, tx_data, read_data};
  assign out_tuser = {tx_valid, status};

endmodule

/* rtl/uart16550_checker.sv */
// Port-level checker for the UART register model and its bind to the top level.
module uart16550_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import uart16550_pkg::*;

  // One request at a time: no request is taken in the cycle after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted right after another request");

  // Only drained bytes may end a run early; every other response is final and carries no byte.
  a_nondrain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tlast && out_tdata[15:8] == 8'h00))
    else $error("response without transmit byte is not final or carries a byte");

  // A faulted access returns no read data.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != ST_OK) |-> (out_tdata[7:0] == 8'h00 && !out_tuser[2]))
    else $error("faulted access returned data");

  // A stalled response holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled response changed");

endmodule

bind uart_16550_register_model_unit uart16550_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
